### design/dpb_pkg.sv
// Shared types, constants and saturation helpers for the depth pixel back-projection block.
package dpb_pkg;

	localparam int unsigned QUOT_BITS = 32;
	localparam int unsigned DEN_BITS  = 36;

	typedef enum logic [3:0] {
		REG_ROT0   = 4'd0,
		REG_ROT1   = 4'd1,
		REG_ROT2   = 4'd2,
		REG_TRANS  = 4'd3,
		REG_PP     = 4'd4,
		REG_IFOC   = 4'd5,
		REG_DSCALE = 4'd6,
		REG_FTAG   = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0]        column;
		logic [11:0]        row;
		logic               in_mask;
		logic [15:0]        depth;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               normal_valid;
		logic [7:0]         blue;
		logic [7:0]         green;
		logic [7:0]         red;
	} pixel_t;

	typedef struct packed {
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic signed [15:0] rotated_normal_x;
		logic signed [15:0] rotated_normal_y;
		logic signed [15:0] rotated_normal_z;
		logic [7:0]         out_red;
		logic [7:0]         out_green;
		logic [7:0]         out_blue;
		logic [31:0]        weight;
		logic [15:0]        point_frame;
	} result_t;

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [38:0] v);
		logic signed [23:0] r;
		if (v > 39'sd8388607) begin
			r = 24'sh7fffff;
		end else if (v < -39'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

### design/dpb_recip.sv
// Pipelined restoring divider that forms 2^40 over a squared depth, one quotient bit per stage.
module dpb_recip
	import dpb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [DEN_BITS-1:0]  in_den,
	output logic                 out_valid,
	output logic [QUOT_BITS-1:0] out_quot
);

	logic                 vld_q [1:QUOT_BITS];
	logic                 sat_q [1:QUOT_BITS];
	logic [DEN_BITS:0]    rem_q [1:QUOT_BITS];
	logic [DEN_BITS-1:0]  den_q [1:QUOT_BITS];
	logic [QUOT_BITS-1:0] quo_q [1:QUOT_BITS];

	genvar j;
	generate
		for (j = 1; j <= QUOT_BITS; j++) begin : g_stage
			logic                 pv;
			logic                 ps;
			logic [DEN_BITS:0]    prem;
			logic [DEN_BITS-1:0]  pden;
			logic [QUOT_BITS-1:0] pquo;
			logic [DEN_BITS:0]    shifted;
			logic                 take;

			if (j == 1) begin : g_first
				// The top bits of 2^40 start the remainder at 256.
				assign pv   = in_valid;
				assign ps   = (in_den < 36'd257);
				assign prem = 37'd256;
				assign pden = in_den;
				assign pquo = '0;
			end else begin : g_next
				assign pv   = vld_q[j-1];
				assign ps   = sat_q[j-1];
				assign prem = rem_q[j-1];
				assign pden = den_q[j-1];
				assign pquo = quo_q[j-1];
			end

			assign shifted = {prem[DEN_BITS-1:0], 1'b0};
			assign take    = (shifted >= {1'b0, pden});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[j] <= 1'b0;
				end else begin
					vld_q[j] <= pv;
				end
			end

			always_ff @(posedge clk) begin
				sat_q[j] <= ps;
				den_q[j] <= pden;
				rem_q[j] <= take ? (shifted - {1'b0, pden}) : shifted;
				quo_q[j] <= {pquo[QUOT_BITS-2:0], take};
			end
		end
	endgenerate

	assign out_valid = vld_q[QUOT_BITS];
	assign out_quot  = sat_q[QUOT_BITS] ? '1 : quo_q[QUOT_BITS];

endmodule

### design/depth_pixel_backprojection.sv
// Top level of the RGB-D pixel back-projection pipeline with its configuration registers.
// One pixel item is taken in every clock cycle and busy is never raised. An item that becomes
// a point leaves on result with done high after stages 1 to 4, the divider and the output
// register; items that are masked out, carry an invalid normal or scale to zero depth leave
// nothing. The 32-stage divider forms the weight, one quotient bit per stage, after four
// stages that find the squared depth. Results cannot be held off and must be taken when shown.
module depth_pixel_backprojection
	import dpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  pixel_t      pixel,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_index,
	input  logic [62:0] cfg_data
);

	localparam int unsigned DLY = 26;

	logic [47:0] rot_q [3];
	logic [62:0] trans_q;
	logic [31:0] pp_q;
	logic [47:0] ifoc_q;
	logic [15:0] dscale_q;
	logic [15:0] ftag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'd16384;
			rot_q[1] <= 48'd1073741824;
			rot_q[2] <= 48'd70368744177664;
			trans_q  <= '0;
			pp_q     <= '0;
			ifoc_q   <= '0;
			dscale_q <= 16'd16384;
			ftag_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROT0:   rot_q[0] <= cfg_data[47:0];
				REG_ROT1:   rot_q[1] <= cfg_data[47:0];
				REG_ROT2:   rot_q[2] <= cfg_data[47:0];
				REG_TRANS:  trans_q  <= cfg_data;
				REG_PP:     pp_q     <= cfg_data[31:0];
				REG_IFOC:   ifoc_q   <= cfg_data[47:0];
				REG_DSCALE: dscale_q <= cfg_data[15:0];
				REG_FTAG:   ftag_q   <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: capture the pixel.
	logic   v_s1;
	pixel_t pix_s1;

	// Stage 2: depth product and normal products.
	logic               v_s2;
	pixel_t             pix_s2;
	logic [31:0]        dprod_s2;
	logic signed [31:0] nprod_s2 [3][3];

	// Stage 3: depth in millimetres, pixel offsets, normal sums.
	logic               v_s3;
	pixel_t             pix_s3;
	logic [17:0]        z_s3;
	logic signed [16:0] dx_s3;
	logic signed [16:0] dy_s3;
	logic signed [33:0] nsum_s3 [3];

	// Stage 4: offset times depth, rotated normal, squared depth.
	logic               v_s4;
	pixel_t             pix_s4;
	logic [17:0]        z_s4;
	logic signed [35:0] dxz_s4;
	logic signed [35:0] dyz_s4;
	logic signed [15:0] nrot_s4 [3];
	logic [35:0]        zz_s4;

	// Stage 5: partial products with the inverse focal lengths.
	logic               v_s5;
	pixel_t             pix_s5;
	logic [17:0]        z_s5;
	logic signed [48:0] xl_s5, xh_s5, yl_s5, yh_s5;
	logic signed [15:0] nrot_s5 [3];

	// Stage 6: combined products.
	logic               v_s6;
	pixel_t             pix_s6;
	logic [17:0]        z_s6;
	logic signed [60:0] xp_s6, yp_s6;
	logic signed [15:0] nrot_s6 [3];

	// Stage 7: camera-frame coordinates.
	logic               v_s7;
	pixel_t             pix_s7;
	logic [17:0]        z_s7;
	logic signed [31:0] x_s7, y_s7;
	logic signed [15:0] nrot_s7 [3];

	// Stage 8: rotation products.
	logic               v_s8;
	pixel_t             pix_s8;
	logic signed [49:0] pr_s8 [3][3];
	logic signed [15:0] nrot_s8 [3];

	// Stage 9: rotation sums.
	logic               v_s9;
	pixel_t             pix_s9;
	logic signed [51:0] psum_s9 [3];
	logic signed [15:0] nrot_s9 [3];

	// Stage 10: rounded, translated and saturated point.
	logic    v_s10;
	result_t res_s10;

	logic signed [51:0] psum_r [3];
	logic signed [38:0] pt_w [3];
	logic signed [20:0] t_w [3];
	logic signed [33:0] nsum_r [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1  <= start && !busy && pixel.in_mask && pixel.normal_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2 && (dprod_s2 + 32'd8192 >= 32'd16384 || dprod_s2 > 32'hffffdfff);
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t_w[i]    = trans_q[21*i +: 21];
			nsum_r[i] = nsum_s3[i] + 34'sd8192;
			psum_r[i] = psum_s9[i] + 52'sd8192;
			pt_w[i]   = 39'(psum_r[i] >>> 14) + 39'(t_w[i]);
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= pixel;

		pix_s2   <= pix_s1;
		dprod_s2 <= pix_s1.depth * dscale_q;
		for (int i = 0; i < 3; i++) begin
			nprod_s2[i][0] <= $signed(rot_q[i][15:0])  * pix_s1.norm_x;
			nprod_s2[i][1] <= $signed(rot_q[i][31:16]) * pix_s1.norm_y;
			nprod_s2[i][2] <= $signed(rot_q[i][47:32]) * pix_s1.norm_z;
		end

		pix_s3 <= pix_s2;
		z_s3   <= 18'((33'(dprod_s2) + 33'd8192) >> 14);
		dx_s3  <= $signed({1'b0, pix_s2.column, 4'b0000}) - $signed({1'b0, pp_q[15:0]});
		dy_s3  <= $signed({1'b0, pix_s2.row, 4'b0000}) - $signed({1'b0, pp_q[31:16]});
		for (int i = 0; i < 3; i++) begin
			nsum_s3[i] <= 34'(nprod_s2[i][0]) + 34'(nprod_s2[i][1]) + 34'(nprod_s2[i][2]);
		end

		pix_s4 <= pix_s3;
		z_s4   <= z_s3;
		dxz_s4 <= dx_s3 * $signed({1'b0, z_s3});
		dyz_s4 <= dy_s3 * $signed({1'b0, z_s3});
		zz_s4  <= z_s3 * z_s3;
		for (int i = 0; i < 3; i++) begin
			nrot_s4[i] <= sat16(20'(nsum_r[i] >>> 14));
		end

		pix_s5  <= pix_s4;
		z_s5    <= z_s4;
		xl_s5   <= dxz_s4 * $signed({1'b0, ifoc_q[11:0]});
		xh_s5   <= dxz_s4 * $signed({1'b0, ifoc_q[23:12]});
		yl_s5   <= dyz_s4 * $signed({1'b0, ifoc_q[35:24]});
		yh_s5   <= dyz_s4 * $signed({1'b0, ifoc_q[47:36]});
		nrot_s5 <= nrot_s4;

		pix_s6  <= pix_s5;
		z_s6    <= z_s5;
		xp_s6   <= 61'(xl_s5) + (61'(xh_s5) <<< 12);
		yp_s6   <= 61'(yl_s5) + (61'(yh_s5) <<< 12);
		nrot_s6 <= nrot_s5;

		pix_s7  <= pix_s6;
		z_s7    <= z_s6;
		x_s7    <= 32'((xp_s6 + 61'sd134217728) >>> 28);
		y_s7    <= 32'((yp_s6 + 61'sd134217728) >>> 28);
		nrot_s7 <= nrot_s6;

		pix_s8  <= pix_s7;
		nrot_s8 <= nrot_s7;
		for (int i = 0; i < 3; i++) begin
			pr_s8[i][0] <= 50'($signed(rot_q[i][15:0]) * x_s7);
			pr_s8[i][1] <= 50'($signed(rot_q[i][31:16]) * y_s7);
			pr_s8[i][2] <= 50'($signed(rot_q[i][47:32]) * $signed({1'b0, z_s7}));
		end

		pix_s9  <= pix_s8;
		nrot_s9 <= nrot_s8;
		for (int i = 0; i < 3; i++) begin
			psum_s9[i] <= 52'(pr_s8[i][0]) + 52'(pr_s8[i][1]) + 52'(pr_s8[i][2]);
		end

		res_s10.point_x          <= sat24(pt_w[0]);
		res_s10.point_y          <= sat24(pt_w[1]);
		res_s10.point_z          <= sat24(pt_w[2]);
		res_s10.rotated_normal_x <= nrot_s9[0];
		res_s10.rotated_normal_y <= nrot_s9[1];
		res_s10.rotated_normal_z <= nrot_s9[2];
		res_s10.out_red          <= pix_s9.red;
		res_s10.out_green        <= pix_s9.green;
		res_s10.out_blue         <= pix_s9.blue;
		res_s10.weight           <= '0;
		res_s10.point_frame      <= ftag_q;
	end

	// The divider runs alongside; the point waits in a delay line until the weight is ready.
	logic                 div_valid;
	logic [QUOT_BITS-1:0] div_quot;

	dpb_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_den    (zz_s4),
		.out_valid (div_valid),
		.out_quot  (div_quot)
	);

	logic    dly_vld_q [DLY];
	result_t dly_res_q [DLY];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DLY; k++) begin
				dly_vld_q[k] <= 1'b0;
			end
		end else begin
			dly_vld_q[0] <= v_s10;
			for (int k = 1; k < DLY; k++) begin
				dly_vld_q[k] <= dly_vld_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dly_res_q[0] <= res_s10;
		for (int k = 1; k < DLY; k++) begin
			dly_res_q[k] <= dly_res_q[k-1];
		end
	end

	logic    done_q;
	result_t result_q;
	result_t result_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_comb begin
		result_w        = dly_res_q[DLY-1];
		result_w.weight = div_quot;
	end

	always_ff @(posedge clk) begin
		result_q <= result_w;
	end

	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		div_valid == dly_vld_q[DLY-1])
		else $error("Weight divider and point delay line are out of step.");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		dly_vld_q[DLY-1] |=> done)
		else $error("A finished point item was not delivered.");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(dly_vld_q[DLY-1]))
		else $error("Result strobe raised without a finished point item.");
`endif

endmodule

### tb/sv/depth_pixel_backprojection_tb.sv
// Self-checking testbench for the depth pixel back-projection block with a scoreboard class.
module depth_pixel_backprojection_tb
	import dpb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 37;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 235;
	localparam int NUM_PHASES = 6;

	class point_scoreboard;
		logic [62:0] regs [8];
		result_t     pending_points [$];
		int          mismatches;
		int          points_checked;

		function new();
			regs[REG_ROT0]   = 63'd16384;
			regs[REG_ROT1]   = 63'd1 << 30;
			regs[REG_ROT2]   = 63'd1 << 46;
			regs[REG_TRANS]  = '0;
			regs[REG_PP]     = '0;
			regs[REG_IFOC]   = '0;
			regs[REG_DSCALE] = 63'd16384;
			regs[REG_FTAG]   = '0;
			mismatches = 0;
			points_checked = 0;
		endfunction

		function void write_reg(logic [3:0] idx, logic [62:0] data);
			logic [62:0] m;
			case (idx)
				REG_ROT0, REG_ROT1, REG_ROT2, REG_IFOC: m = {15'd0, {48{1'b1}}};
				REG_TRANS: m = '1;
				REG_PP: m = {31'd0, {32{1'b1}}};
				REG_DSCALE, REG_FTAG: m = {47'd0, {16{1'b1}}};
				default: return;
			endcase
			regs[idx] = data & m;
		endfunction

		function longint round_shift(longint p, int s);
			return (p + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function longint clamp(longint v, int w);
			longint hi, lo;
			hi = (longint'(1) << (w - 1)) - 1;
			lo = -hi - 1;
			return v > hi ? hi : (v < lo ? lo : v);
		endfunction

		function void note_pixel(pixel_t p);
			result_t r;
			longint z, dx, dy, ifx, ify, pv, nv, r0, r1, r2;
			longint cam [3];
			longint nrm [3];
			longint t [3];
			logic [63:0] wgt;
			logic [47:0] rowv;
			if (!p.in_mask || !p.normal_valid) return;
			z = (longint'(p.depth) * longint'(regs[REG_DSCALE][15:0]) + 8192) >>> 14;
			if (z <= 0) return;
			dx = longint'(p.column) * 16 - longint'(regs[REG_PP][15:0]);
			dy = longint'(p.row) * 16 - longint'(regs[REG_PP][31:16]);
			ifx = longint'(regs[REG_IFOC][23:0]);
			ify = longint'(regs[REG_IFOC][47:24]);
			cam[0] = round_shift(dx * z * ifx, 28);
			cam[1] = round_shift(dy * z * ify, 28);
			cam[2] = z;
			nrm[0] = p.norm_x;
			nrm[1] = p.norm_y;
			nrm[2] = p.norm_z;
			t[0] = $signed(regs[REG_TRANS][20:0]);
			t[1] = $signed(regs[REG_TRANS][41:21]);
			t[2] = $signed(regs[REG_TRANS][62:42]);
			for (int i = 0; i < 3; i++) begin
				rowv = regs[i][47:0];
				r0 = $signed(rowv[15:0]);
				r1 = $signed(rowv[31:16]);
				r2 = $signed(rowv[47:32]);
				pv = clamp(round_shift(r0 * cam[0] + r1 * cam[1] + r2 * cam[2], 14) + t[i], 24);
				nv = clamp(round_shift(r0 * nrm[0] + r1 * nrm[1] + r2 * nrm[2], 14), 16);
				case (i)
					0: begin r.point_x = pv[23:0]; r.rotated_normal_x = nv[15:0]; end
					1: begin r.point_y = pv[23:0]; r.rotated_normal_y = nv[15:0]; end
					default: begin r.point_z = pv[23:0]; r.rotated_normal_z = nv[15:0]; end
				endcase
			end
			r.out_red = p.red;
			r.out_green = p.green;
			r.out_blue = p.blue;
			wgt = (64'd1 << 40) / (64'(z) * 64'(z));
			r.weight = wgt > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : wgt[31:0];
			r.point_frame = regs[REG_FTAG][15:0];
			pending_points.insert(pending_points.size(), r);
		endfunction

		function void check_point(result_t got);
			result_t e;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected point %h", got);
				return;
			end
			e = pending_points.pop_front();
			points_checked++;
			if (got.point_x !== e.point_x || got.point_y !== e.point_y ||
			    got.point_z !== e.point_z || got.rotated_normal_x !== e.rotated_normal_x ||
			    got.rotated_normal_y !== e.rotated_normal_y ||
			    got.rotated_normal_z !== e.rotated_normal_z || got.out_red !== e.out_red ||
			    got.out_green !== e.out_green || got.out_blue !== e.out_blue ||
			    got.weight !== e.weight || got.point_frame !== e.point_frame) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: point %0d p=(%h %h %h) n=(%h %h %h) rgb=%h%h%h w=%h f=%h",
						points_checked, got.point_x, got.point_y, got.point_z,
						got.rotated_normal_x, got.rotated_normal_y, got.rotated_normal_z,
						got.out_red, got.out_green, got.out_blue, got.weight, got.point_frame);
					$display("       expected p=(%h %h %h) n=(%h %h %h) rgb=%h%h%h w=%h f=%h",
						e.point_x, e.point_y, e.point_z,
						e.rotated_normal_x, e.rotated_normal_y, e.rotated_normal_z,
						e.out_red, e.out_green, e.out_blue, e.weight, e.point_frame);
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	pixel_t      pixel = '0;
	logic        done;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [3:0]  cfg_index = '0;
	logic [62:0] cfg_data = '0;

	point_scoreboard sb = new();
	int idle_cycles = 0;
	int items_sent = 0;
	int idle_pct = 0;

	depth_pixel_backprojection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .pixel(pixel),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (done) sb.check_point(result);
		if ((start && !busy) || done) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_pixel(pixel_t p);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		pixel <= p;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_pixel(p);
		items_sent++;
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		while (sb.pending_points.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [62:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	function automatic logic [62:0] rand63();
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		return rnd[62:0];
	endfunction

	task automatic configure(int kind);
		logic [62:0] d;
		for (int i = 0; i < 8; i++) begin
			case (kind)
				1: d = '1;
				2: d = (i == REG_DSCALE) ? 63'hFFFF : '0;
				3: case (i)
					REG_ROT0: d = 63'h0000_0000_4000;
					REG_ROT1: d = 63'h0000_4000_0000;
					REG_ROT2: d = 63'h4000_0000_0000;
					REG_PP: d = {31'd0, 16'd3840, 16'd5120};
					REG_IFOC: d = {15'd0, 24'd31957, 24'd31957};
					REG_DSCALE: d = 63'd16384;
					default: d = rand63();
				endcase
				default: d = rand63();
			endcase
			write_reg(4'(i), d);
		end
		write_reg(4'(REG_FTAG) + 4'(1) + 4'($urandom_range(0, 7)), rand63());
		cfg_we <= 1'b0;
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [159:0] rnd;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
		p = rnd[$bits(pixel_t)-1:0];
		if ($urandom_range(0, 99) < 75) begin
			p.in_mask = 1'b1;
			p.normal_valid = 1'b1;
			if ($urandom_range(0, 3) != 0) p.depth = 16'($urandom_range(1, 8000));
		end
		return p;
	endfunction

	function automatic pixel_t make_pixel(logic [11:0] c, logic [11:0] r, logic m,
		logic [15:0] d, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, logic v,
		logic [7:0] col);
		pixel_t p;
		p.column = c; p.row = r; p.in_mask = m; p.depth = d;
		p.norm_x = nx; p.norm_y = ny; p.norm_z = nz; p.normal_valid = v;
		p.blue = col; p.green = ~col; p.red = col ^ 8'h5a;
		return p;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: zero inverse focal, identity pose.
		send_pixel(make_pixel(12'd0, 12'd0, 1'b1, 16'd1000, 16'h4000, 16'h0, 16'h0, 1'b1, 8'h00));
		send_pixel(make_pixel(12'hFFF, 12'hFFF, 1'b1, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF,
			1'b1, 8'hFF));
		send_pixel(make_pixel(12'd5, 12'd6, 1'b1, 16'd1, 16'h1234, 16'h0, 16'h0, 1'b1, 8'h11));
		send_pixel(make_pixel(12'd5, 12'd6, 1'b1, 16'd0, 16'h1234, 16'h0, 16'h0, 1'b1, 8'h22));
		send_pixel(make_pixel(12'd5, 12'd6, 1'b0, 16'd900, 16'h1234, 16'h0, 16'h0, 1'b1, 8'h33));
		send_pixel(make_pixel(12'd5, 12'd6, 1'b1, 16'd900, 16'h1234, 16'h0, 16'h0, 1'b0, 8'h44));
		drain_pipeline();
		configure(3);
		send_pixel(make_pixel(12'd0, 12'd0, 1'b1, 16'd500, 16'h8000, 16'h8000, 16'h8000, 1'b1,
			8'h01));
		send_pixel(make_pixel(12'hFFF, 12'hFFF, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b1, 8'hFE));
		send_pixel(make_pixel(12'd320, 12'd240, 1'b1, 16'd2, 16'h0, 16'h4000, 16'h0, 1'b1,
			8'h80));
		send_pixel(make_pixel(12'd100, 12'd4000, 1'b1, 16'd65535, 16'h0, 16'h0, 16'h4000,
			1'b1, 8'h7F));
		drain_pipeline();
		write_reg(REG_DSCALE, 63'd8191);
		cfg_we <= 1'b0;
		// Scaled depth that rounds to zero, then the smallest depth that survives.
		send_pixel(make_pixel(12'd9, 12'd9, 1'b1, 16'd1, 16'h4000, 16'h0, 16'h0, 1'b1, 8'h55));
		send_pixel(make_pixel(12'd9, 12'd9, 1'b1, 16'd2, 16'h4000, 16'h0, 16'h0, 1'b1, 8'h66));
		drain_pipeline();
		configure(1);
		send_pixel(make_pixel(12'hFFF, 12'd0, 1'b1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000,
			1'b1, 8'hAA));
		send_pixel(make_pixel(12'd0, 12'hFFF, 1'b1, 16'd1, 16'h7FFF, 16'h8000, 16'h7FFF,
			1'b1, 8'h0F));
		drain_pipeline();
		configure(2);
		send_pixel(make_pixel(12'd77, 12'd88, 1'b1, 16'd3000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			1'b1, 8'hC3));
		drain_pipeline();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			configure(ph == 2 ? 1 : (ph == 4 ? 3 : 0));
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 86;
				2: idle_pct = 11;
				default: idle_pct = 86;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 60 == 30) idle_pct = (idle_pct == 0) ? 86 : 0;
				send_pixel(random_pixel());
			end
			drain_pipeline();
		end

		if (sb.pending_points.size() != 0) sb.mismatches += sb.pending_points.size();
		$display("Sent %0d pixel items over %0d register settings; %0d points checked.",
			items_sent, NUM_PHASES + 5, sb.points_checked);
		$display("Mismatches: %0d", sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### files.f
design/dpb_pkg.sv
design/dpb_recip.sv
design/depth_pixel_backprojection.sv
tb/sv/depth_pixel_backprojection_tb.sv
